// File: sv/assert_macros.svh
// Assertion macros shared by the line follower RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked property, disabled while reset is asserted (active low).
`define LFPD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("lfpd assertion failed");
// Clocked property checked during reset as well.
`define LFPD_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("lfpd assertion failed");
`else
`define LFPD_ASSERT(lbl, clk, rst_n, prop)
`define LFPD_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// File: sv/lfpd_pkg.sv
// Shared types, constants and helpers of the line follower PID drive.
`default_nettype none
package lfpd_pkg;

    // Field widths
    localparam int SAMPLE_BITS_DEF = 10;
    localparam int GAIN_W          = 16;
    localparam int ZONE_W          = 10;
    localparam int TGT_W           = 10;
    localparam int ACC_W           = 32;
    localparam int DRIVE_W         = 8;
    localparam int FRAC_BITS       = 12;
    localparam int CORR_W          = 9;
    localparam int DCALC_W         = 11;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_PROP   = 3'd0,
        CFG_GAIN_INTEG  = 3'd1,
        CFG_GAIN_DERIV  = 3'd2,
        CFG_INTEG_ZONE  = 3'd3,
        CFG_TGT_FORWARD = 3'd4,
        CFG_TGT_REVERSE = 3'd5
    } t_cfg_idx;

    // Register reset values
    localparam logic signed [GAIN_W-1:0] RST_GAIN_PROP  = 16'sd82;
    localparam logic signed [GAIN_W-1:0] RST_GAIN_INTEG = 16'sd0;
    localparam logic signed [GAIN_W-1:0] RST_GAIN_DERIV = 16'sd0;
    localparam logic [ZONE_W-1:0]        RST_INTEG_ZONE = 10'd10;
    localparam logic [TGT_W-1:0]         RST_TGT_FWD    = 10'd772;
    localparam logic [TGT_W-1:0]         RST_TGT_REV    = 10'd770;

    // Correction limit and drive windows
    localparam int CORR_LIM      = 255;
    localparam int BASE_FWD_LEFT = 75;
    localparam int BASE_FWD_RGHT = 105;
    localparam int BASE_REV_LEFT = 112;
    localparam int BASE_REV_RGHT = 75;
    localparam int SLOW_LO       = 0;
    localparam int SLOW_HI       = 80;
    localparam int FAST_LO       = 100;
    localparam int FAST_HI       = 180;

    typedef struct packed {
        logic signed [GAIN_W-1:0] gain_prop;
        logic signed [GAIN_W-1:0] gain_integ;
        logic signed [GAIN_W-1:0] gain_deriv;
        logic [ZONE_W-1:0]        integ_zone;
        logic [TGT_W-1:0]         tgt_fwd;
        logic [TGT_W-1:0]         tgt_rev;
    } t_cfg;

    // Clamp a signed speed to [lo, hi]
    function automatic logic [DRIVE_W-1:0] clamp_drive(
        input logic signed [DCALC_W-1:0] v,
        input int lo,
        input int hi
    );
        logic [DRIVE_W-1:0] res;
        if (v < DCALC_W'(lo)) begin
            res = DRIVE_W'(lo);
        end else if (v > DCALC_W'(hi)) begin
            res = DRIVE_W'(hi);
        end else begin
            res = v[DRIVE_W-1:0];
        end
        return res;
    endfunction

endpackage
`default_nettype wire

// File: sv/lfpd_cfg_regs.sv
// Configuration register file of the line follower PID drive.
`default_nettype none
module lfpd_cfg_regs (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [lfpd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [lfpd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output lfpd_pkg::t_cfg                       o_cfg
);

    lfpd_pkg::t_cfg r_cfg;

    // Register writes, unknown indexes dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_prop  <= lfpd_pkg::RST_GAIN_PROP;
            r_cfg.gain_integ <= lfpd_pkg::RST_GAIN_INTEG;
            r_cfg.gain_deriv <= lfpd_pkg::RST_GAIN_DERIV;
            r_cfg.integ_zone <= lfpd_pkg::RST_INTEG_ZONE;
            r_cfg.tgt_fwd    <= lfpd_pkg::RST_TGT_FWD;
            r_cfg.tgt_rev    <= lfpd_pkg::RST_TGT_REV;
        end else if (i_cfg_we) begin
            unique case (lfpd_pkg::t_cfg_idx'(i_cfg_idx))
                lfpd_pkg::CFG_GAIN_PROP: begin
                    r_cfg.gain_prop <= signed'(i_cfg_data[lfpd_pkg::GAIN_W-1:0]);
                end
                lfpd_pkg::CFG_GAIN_INTEG: begin
                    r_cfg.gain_integ <= signed'(i_cfg_data[lfpd_pkg::GAIN_W-1:0]);
                end
                lfpd_pkg::CFG_GAIN_DERIV: begin
                    r_cfg.gain_deriv <= signed'(i_cfg_data[lfpd_pkg::GAIN_W-1:0]);
                end
                lfpd_pkg::CFG_INTEG_ZONE: begin
                    r_cfg.integ_zone <= i_cfg_data[lfpd_pkg::ZONE_W-1:0];
                end
                lfpd_pkg::CFG_TGT_FORWARD: begin
                    r_cfg.tgt_fwd <= i_cfg_data[lfpd_pkg::TGT_W-1:0];
                end
                lfpd_pkg::CFG_TGT_REVERSE: begin
                    r_cfg.tgt_rev <= i_cfg_data[lfpd_pkg::TGT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

// File: sv/lfpd_pid_core.sv
// PID datapath: error, integral and derivative state, correction and clamps.
`default_nettype none
`include "assert_macros.svh"
module lfpd_pid_core #(
    parameter int SAMPLE_BITS = lfpd_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_fire,
    input  wire logic                          i_mode,
    input  wire logic [SAMPLE_BITS-1:0]        i_position,
    input  lfpd_pkg::t_cfg                     i_cfg,
    output logic      [lfpd_pkg::DRIVE_W-1:0]  o_left_drive,
    output logic      [lfpd_pkg::DRIVE_W-1:0]  o_right_drive
);

    // Error is one bit wider than the wider of target and sample
    localparam int MAG_W  = (SAMPLE_BITS > lfpd_pkg::TGT_W) ? SAMPLE_BITS : lfpd_pkg::TGT_W;
    localparam int ERR_W  = MAG_W + 1;
    localparam int P_W    = lfpd_pkg::GAIN_W + ERR_W;
    localparam int D_W    = lfpd_pkg::GAIN_W + ERR_W + 1;
    localparam int AS_W   = ((P_W > lfpd_pkg::ACC_W) ? P_W : lfpd_pkg::ACC_W) + 1;
    localparam int SUM_W  = ((D_W > lfpd_pkg::ACC_W) ? D_W : lfpd_pkg::ACC_W) + 2;
    localparam int DC_W   = lfpd_pkg::DCALC_W;

    localparam logic signed [AS_W-1:0] ACC_HI =
        AS_W'(signed'({1'b0, {(lfpd_pkg::ACC_W-1){1'b1}}}));
    localparam logic signed [AS_W-1:0] ACC_LO =
        AS_W'(signed'({1'b1, {(lfpd_pkg::ACC_W-1){1'b0}}}));
    localparam logic signed [SUM_W-1:0] ROUND_BIAS =
        SUM_W'((2 ** lfpd_pkg::FRAC_BITS) - 1);
    localparam logic signed [SUM_W-1:0] CORR_HI = SUM_W'(lfpd_pkg::CORR_LIM);
    localparam logic signed [SUM_W-1:0] CORR_LO = SUM_W'(-lfpd_pkg::CORR_LIM);

    logic signed [lfpd_pkg::ACC_W-1:0] r_integ_acc;
    logic signed [ERR_W-1:0]           r_last_err;
    logic signed [lfpd_pkg::ACC_W-1:0] n_integ_acc;

    logic [lfpd_pkg::TGT_W-1:0]        target;
    logic signed [ERR_W-1:0]           err;
    logic [MAG_W-1:0]                  mag;
    logic                              in_zone;
    logic signed [P_W-1:0]             p_term;
    logic signed [P_W-1:0]             i_prod;
    logic signed [AS_W-1:0]            i_sum;
    logic signed [ERR_W:0]             err_diff;
    logic signed [D_W-1:0]             d_term;
    logic signed [SUM_W-1:0]           pid_sum;
    logic signed [SUM_W-1:0]           pid_quot;
    logic signed [lfpd_pkg::CORR_W-1:0] corr;
    logic signed [DC_W-1:0]            corr_x;
    logic signed [DC_W-1:0]            left_raw;
    logic signed [DC_W-1:0]            right_raw;

    // Error and its magnitude
    always_comb begin
        target  = i_mode ? i_cfg.tgt_rev : i_cfg.tgt_fwd;
        err     = signed'(ERR_W'(target)) - signed'(ERR_W'(i_position));
        mag     = err[ERR_W-1] ? MAG_W'(-err) : MAG_W'(err);
        in_zone = mag < MAG_W'(i_cfg.integ_zone);
    end

    // Three gain products
    always_comb begin
        p_term   = P_W'(i_cfg.gain_prop) * P_W'(err);
        i_prod   = P_W'(i_cfg.gain_integ) * P_W'(err);
        err_diff = (ERR_W+1)'(err) - (ERR_W+1)'(r_last_err);
        d_term   = D_W'(i_cfg.gain_deriv) * D_W'(err_diff);
    end

    // Integral update, saturating, cleared outside the zone
    always_comb begin
        i_sum = AS_W'(r_integ_acc) + AS_W'(i_prod);
        if (!in_zone) begin
            n_integ_acc = '0;
        end else if (i_sum > ACC_HI) begin
            n_integ_acc = ACC_HI[lfpd_pkg::ACC_W-1:0];
        end else if (i_sum < ACC_LO) begin
            n_integ_acc = ACC_LO[lfpd_pkg::ACC_W-1:0];
        end else begin
            n_integ_acc = i_sum[lfpd_pkg::ACC_W-1:0];
        end
    end

    // Sum, truncate toward zero, saturate the correction
    always_comb begin
        pid_sum  = SUM_W'(p_term) + SUM_W'(n_integ_acc) + SUM_W'(d_term);
        pid_quot = (pid_sum[SUM_W-1] ? (pid_sum + ROUND_BIAS) : pid_sum)
                   >>> lfpd_pkg::FRAC_BITS;
        if (pid_quot > CORR_HI) begin
            corr = CORR_HI[lfpd_pkg::CORR_W-1:0];
        end else if (pid_quot < CORR_LO) begin
            corr = CORR_LO[lfpd_pkg::CORR_W-1:0];
        end else begin
            corr = pid_quot[lfpd_pkg::CORR_W-1:0];
        end
        corr_x = DC_W'(corr);
    end

    // Base speeds offset by the correction, then windowed
    always_comb begin
        if (!i_mode) begin
            left_raw      = DC_W'(lfpd_pkg::BASE_FWD_LEFT) - corr_x;
            right_raw     = DC_W'(lfpd_pkg::BASE_FWD_RGHT) - corr_x;
            o_left_drive  = lfpd_pkg::clamp_drive(left_raw, lfpd_pkg::SLOW_LO,
                                                  lfpd_pkg::SLOW_HI);
            o_right_drive = lfpd_pkg::clamp_drive(right_raw, lfpd_pkg::FAST_LO,
                                                  lfpd_pkg::FAST_HI);
        end else begin
            left_raw      = DC_W'(lfpd_pkg::BASE_REV_LEFT) + corr_x;
            right_raw     = DC_W'(lfpd_pkg::BASE_REV_RGHT) + corr_x;
            o_left_drive  = lfpd_pkg::clamp_drive(left_raw, lfpd_pkg::FAST_LO,
                                                  lfpd_pkg::FAST_HI);
            o_right_drive = lfpd_pkg::clamp_drive(right_raw, lfpd_pkg::SLOW_LO,
                                                  lfpd_pkg::SLOW_HI);
        end
    end

    // Controller state advances once per beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ_acc <= '0;
            r_last_err  <= '0;
        end else if (i_fire) begin
            r_integ_acc <= n_integ_acc;
            r_last_err  <= err;
        end
    end

    `LFPD_ASSERT(a_integ_clear, i_clk, i_rst_n, (i_fire && !in_zone) |=> (r_integ_acc == '0))
    `LFPD_ASSERT(a_last_err_tracks, i_clk, i_rst_n, i_fire |=> (r_last_err == $past(err)))
    `LFPD_ASSERT(a_hold_idle, i_clk, i_rst_n, (!i_fire) |=> $stable({r_integ_acc, r_last_err}))

endmodule
`default_nettype wire

// File: sv/line_follow_pid_drive.sv
// Top level of the line follower PID drive: input and result registers.
//
//   channel   direction  handshake                  payload
//   in        sink       i_in_valid / o_in_stall    i_mode, i_position
//   out       source     o_out_valid / i_out_stall  o_left_drive, o_right_drive
//   cfg       sink       i_cfg_we                   i_cfg_idx, i_cfg_data
//
// One beat per cycle unless the result stalls; beats pass the input, then the result register.
// Error, the three gain multiplies, integral update and clamps sit in one stage
// between the input register and the result register.
// Reset (synchronous, active low) restores register defaults and clears the
// integral and previous error; no clearing pass is needed.
// A stall on the result side holds the result register and backs up into the input register.
`default_nettype none
`include "assert_macros.svh"
module line_follow_pid_drive #(
    parameter int SAMPLE_BITS = lfpd_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [lfpd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [lfpd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic                            i_mode,
    input  wire logic [SAMPLE_BITS-1:0]          i_position,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic [lfpd_pkg::DRIVE_W-1:0]         o_left_drive,
    output logic [lfpd_pkg::DRIVE_W-1:0]         o_right_drive
);

    lfpd_pkg::t_cfg cfg;

    logic                          r_in_vld;
    logic                          r_in_mode;
    logic [SAMPLE_BITS-1:0]        r_in_pos;
    logic                          r_out_vld;
    logic [lfpd_pkg::DRIVE_W-1:0]  r_out_left;
    logic [lfpd_pkg::DRIVE_W-1:0]  r_out_right;

    logic                          out_open;
    logic                          fire;
    logic                          in_accept;
    logic [lfpd_pkg::DRIVE_W-1:0]  calc_left;
    logic [lfpd_pkg::DRIVE_W-1:0]  calc_right;

    lfpd_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    lfpd_pid_core #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (fire),
        .i_mode        (r_in_mode),
        .i_position    (r_in_pos),
        .i_cfg         (cfg),
        .o_left_drive  (calc_left),
        .o_right_drive (calc_right)
    );

    // Stage handshake
    always_comb begin
        out_open   = !r_out_vld || !i_out_stall;
        fire       = r_in_vld && out_open;
        o_in_stall = r_in_vld && !out_open;
        in_accept  = i_in_valid && !o_in_stall;
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_accept) begin
            r_in_vld <= 1'b1;
        end else if (fire) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_mode <= i_mode;
            r_in_pos  <= i_position;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_open) begin
            r_out_vld <= fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_left  <= calc_left;
            r_out_right <= calc_right;
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_left_drive  = r_out_left;
    assign o_right_drive = r_out_right;

    `LFPD_ASSERT_ALWAYS(a_reset_empties, i_clk, (!i_rst_n) |=> (!r_in_vld && !r_out_vld))
    `LFPD_ASSERT(a_in_held_until_moved, i_clk, i_rst_n, (r_in_vld && !fire) |=> r_in_vld)
    `LFPD_ASSERT(a_stall_only_when_full, i_clk, i_rst_n, o_in_stall |-> (r_in_vld && r_out_vld))
    `LFPD_ASSERT(a_fire_fills_out, i_clk, i_rst_n, fire |=> r_out_vld)

endmodule
`default_nettype wire
